@@ hw/rtl/mbsp_pkg.sv @@
// Package for the MIDI byte-stream parser: sizes, byte codes, item and result types.
// Used by the interfaces and by every module of the parser.
package mbsp_pkg;

  localparam int unsigned SYSEX_CAPACITY = 4096;
  localparam int unsigned CNT_W          = $clog2(SYSEX_CAPACITY + 1);
  localparam int unsigned LEN_W          = 13;
  localparam int unsigned CHAN_W         = 5;

  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SYX_START_BYTE  = 8'hF0;
  localparam logic [7:0] SYX_END_BYTE    = 8'hF7;
  localparam logic [7:0] COMMON_FIRST    = 8'hF1;
  localparam logic [7:0] REALTIME_FIRST  = 8'hF8;
  localparam logic [3:0] HI_PROG_CHANGE  = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS   = 4'hD;
  localparam logic [7:0] MAKER_ID        = 8'h43;
  localparam logic [3:0] DEVICE_CH_MASK  = 4'hF;

  typedef enum logic [2:0] {
    CLS_DATA      = 3'd0,
    CLS_CHAN      = 3'd1,
    CLS_SYX_START = 3'd2,
    CLS_SYX_END   = 3'd3,
    CLS_COMMON    = 3'd4,
    CLS_REALTIME  = 3'd5
  } cls_e;

  typedef enum logic [1:0] {
    KIND_CHAN     = 2'd0,
    KIND_SYX_BYTE = 2'd1,
    KIND_SYX_END  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    cls_e       cls;
    logic       two_data;
  } item_t;

  typedef struct packed {
    logic              valid;
    item_t             item;
  } q_head_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        status_byte;
    logic [6:0]        data_first;
    logic [6:0]        data_second;
    logic [7:0]        sysex_data;
    logic [LEN_W-1:0]  sysex_length;
    logic [CHAN_W-1:0] syx_channel;
  } res_t;

endpackage

@@ hw/rtl/mbsp_intf.sv @@
// Handshake channels of the MIDI byte-stream parser: received bytes in, results out.
// Depends on mbsp_pkg.
interface mbsp_rx_if import mbsp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbsp_res_if import mbsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        status_byte;
  logic [6:0]        data_first;
  logic [6:0]        data_second;
  logic [7:0]        sysex_data;
  logic [LEN_W-1:0]  sysex_length;
  logic [CHAN_W-1:0] syx_channel;

  modport source (output valid, output kind, output status_byte, output data_first,
                  output data_second, output sysex_data, output sysex_length,
                  output syx_channel, input ready);
  modport sink   (input valid, input kind, input status_byte, input data_first,
                  input data_second, input sysex_data, input sysex_length,
                  input syx_channel, output ready);
endinterface

@@ hw/rtl/mbsp_front.sv @@
// Front end: accepts received bytes and classifies them for the back end.
// Depends on mbsp_pkg and mbsp_rx_if.
module mbsp_front import mbsp_pkg::*; (
  mbsp_rx_if.sink rx_i,
  input  logic    full_i,
  output logic    push_o,
  output item_t   item_o
);

  logic [7:0] b;

  assign b          = rx_i.rx_byte;
  assign rx_i.ready = !full_i;
  assign push_o     = rx_i.valid && !full_i;

  always_comb begin
    item_o.rx_byte  = b;
    item_o.two_data = !((b[7:4] == HI_PROG_CHANGE) || (b[7:4] == HI_CHAN_PRESS));
    if (b == SYX_START_BYTE) begin
      item_o.cls = CLS_SYX_START;
    end else if (b >= REALTIME_FIRST) begin
      item_o.cls = CLS_REALTIME;
    end else if (b == SYX_END_BYTE) begin
      item_o.cls = CLS_SYX_END;
    end else if (b >= COMMON_FIRST) begin
      item_o.cls = CLS_COMMON;
    end else if (b[7]) begin
      item_o.cls = CLS_CHAN;
    end else begin
      item_o.cls = CLS_DATA;
    end
  end

endmodule

@@ hw/rtl/mbsp_fifo.sv @@
// Short queue of classified bytes between front end and back end.
// Depends on mbsp_pkg.
module mbsp_fifo import mbsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_head_t head_o
);

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entry_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hw/rtl/mbsp_back.sv @@
// Back end: running-status and SysEx state, result formation and output register.
// Depends on mbsp_pkg and mbsp_res_if.
module mbsp_back import mbsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_head_t     head_i,
  output logic        pop_o,
  mbsp_res_if.source  res_o
);

  logic [7:0]       running_status_q, running_status_d;
  logic [1:0]       data_seen_q, data_seen_d;
  logic [1:0]       data_needed_q, data_needed_d;
  logic [6:0]       held_data_q, held_data_d;
  logic             in_sysex_q, in_sysex_d;
  logic [CNT_W-1:0] sysex_count_q, sysex_count_d;
  logic [7:0]       sysex_maker_q, sysex_maker_d;
  logic [7:0]       sysex_device_q, sysex_device_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic             step;
  logic             emit;
  logic [7:0]       b;
  logic             stored;
  logic [CNT_W-1:0] cnt_new;
  logic [1:0]       seen_inc;

  // Advance while the output register is free or being drained.
  assign pop_o = head_i.valid && (!out_valid_q || res_o.ready);
  assign step  = pop_o;
  assign b     = head_i.item.rx_byte;

  always_comb begin
    running_status_d = running_status_q;
    data_seen_d      = data_seen_q;
    data_needed_d    = data_needed_q;
    held_data_d      = held_data_q;
    in_sysex_d       = in_sysex_q;
    sysex_count_d    = sysex_count_q;
    sysex_maker_d    = sysex_maker_q;
    sysex_device_d   = sysex_device_q;
    emit             = 1'b0;
    res_d            = '0;
    res_d.kind       = KIND_CHAN;
    stored           = (sysex_count_q < CNT_W'(SYSEX_CAPACITY));
    cnt_new          = stored ? sysex_count_q + CNT_W'(1) : sysex_count_q;
    seen_inc         = data_seen_q + 2'd1;

    if (in_sysex_q) begin
      if (stored) begin
        if (sysex_count_q == CNT_W'(1)) begin
          sysex_maker_d = b;
        end else if (sysex_count_q == CNT_W'(2)) begin
          sysex_device_d = b;
        end
      end
      sysex_count_d = cnt_new;
      if (head_i.item.cls == CLS_SYX_END) begin
        emit               = 1'b1;
        res_d.kind         = KIND_SYX_END;
        res_d.sysex_data   = SYX_END_BYTE;
        res_d.sysex_length = LEN_W'(cnt_new);
        if ((cnt_new > CNT_W'(2)) && (sysex_maker_d == MAKER_ID)) begin
          res_d.syx_channel = {1'b0, sysex_device_d[3:0] & DEVICE_CH_MASK}
                              + CHAN_W'(1);
        end
        in_sysex_d    = 1'b0;
        sysex_count_d = '0;
      end else if (stored) begin
        emit               = 1'b1;
        res_d.kind         = KIND_SYX_BYTE;
        res_d.sysex_data   = b;
        res_d.sysex_length = LEN_W'(cnt_new);
      end
    end else begin
      case (head_i.item.cls)
        CLS_SYX_START: begin
          in_sysex_d         = 1'b1;
          sysex_count_d      = CNT_W'(1);
          sysex_maker_d      = '0;
          sysex_device_d     = '0;
          emit               = 1'b1;
          res_d.kind         = KIND_SYX_BYTE;
          res_d.sysex_data   = b;
          res_d.sysex_length = LEN_W'(1);
        end
        CLS_SYX_END, CLS_COMMON: begin
          running_status_d = '0;
          data_seen_d      = '0;
        end
        CLS_CHAN: begin
          running_status_d = b;
          data_seen_d      = '0;
          data_needed_d    = head_i.item.two_data ? 2'd2 : 2'd1;
        end
        CLS_DATA: begin
          if (running_status_q != '0) begin
            if (seen_inc >= data_needed_q) begin
              data_seen_d       = '0;
              emit              = 1'b1;
              res_d.kind        = KIND_CHAN;
              res_d.status_byte = running_status_q;
              if (data_needed_q == 2'd2) begin
                res_d.data_first  = held_data_q;
                res_d.data_second = b[6:0];
              end else begin
                res_d.data_first  = b[6:0];
              end
            end else begin
              data_seen_d = seen_inc;
              held_data_d = b[6:0];
            end
          end
        end
        default: begin
          // real-time bytes outside SysEx: drop
        end
      endcase
    end

    if (step) begin
      out_valid_d = emit;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_status_q <= '0;
      data_seen_q      <= '0;
      data_needed_q    <= '0;
      held_data_q      <= '0;
      in_sysex_q       <= 1'b0;
      sysex_count_q    <= '0;
      sysex_maker_q    <= '0;
      sysex_device_q   <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        running_status_q <= running_status_d;
        data_seen_q      <= data_seen_d;
        data_needed_q    <= data_needed_d;
        held_data_q      <= held_data_d;
        in_sysex_q       <= in_sysex_d;
        sysex_count_q    <= sysex_count_d;
        sysex_maker_q    <= sysex_maker_d;
        sysex_device_q   <= sysex_device_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.status_byte  = res_q.status_byte;
  assign res_o.data_first   = res_q.data_first;
  assign res_o.data_second  = res_q.data_second;
  assign res_o.sysex_data   = res_q.sysex_data;
  assign res_o.sysex_length = res_q.sysex_length;
  assign res_o.syx_channel  = res_q.syx_channel;

`ifndef SYNTHESIS
  a_sysex_count_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sysex_q == (sysex_count_q != '0))
    else $error("sysex count disagrees with sysex open flag");

  a_sysex_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sysex_count_q <= CNT_W'(SYSEX_CAPACITY))
    else $error("sysex count beyond capacity");

  a_data_seen_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_seen_q < 2'd2)
    else $error("data count past message length");

  a_chan_has_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.kind == KIND_CHAN)) |-> res_q.status_byte[7])
    else $error("channel result without a status byte");
`endif

endmodule

@@ hw/rtl/midi_byte_stream_parser.sv @@
// MIDI byte-stream parser with running status and SysEx streaming.
// An accepted byte is queued; its result is formed from the queue head and registered.
// Throughput: one byte per cycle; the two-entry queue and the output register keep
// the input open while a result waits. rx ready drops only when the queue is full.
// Reset (rst_ni, asynchronous, active low) clears running status, SysEx state and valids.
module midi_byte_stream_parser import mbsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbsp_rx_if.sink    rx_i,
  mbsp_res_if.source res_o
);

  logic    push;
  logic    full;
  logic    pop;
  item_t   item;
  q_head_t head;

  mbsp_front u_front (
    .rx_i   (rx_i),
    .full_i (full),
    .push_o (push),
    .item_o (item)
  );

  mbsp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  mbsp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

@@ bench/midi_byte_stream_parser_test.sv @@
// Self-checking bench for midi_byte_stream_parser: directed and random MIDI byte requests,
// a running-status and SysEx predictor in a scoreboard class, random gaps on both sides.
// Depends on mbsp_pkg, mbsp_rx_if and mbsp_res_if from the RTL.
module midi_byte_stream_parser_test import mbsp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned HOLD_CYCLES  = 150;

  class parser_scoreboard;
    res_t        pending[$];
    logic [7:0]  cur_status;
    logic [1:0]  got_count;
    logic [1:0]  need_count;
    logic [6:0]  first_data;
    bit          sysex_open;
    logic [31:0] sysex_len;
    logic [7:0]  maker_id;
    logic [7:0]  device_id;
    int unsigned faults;

    function new();
      cur_status = '0;
      got_count  = '0;
      need_count = '0;
      first_data = '0;
      sysex_open = 1'b0;
      sysex_len  = '0;
      maker_id   = '0;
      device_id  = '0;
      faults     = 0;
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Advance the parser state by one accepted byte and queue the result it causes.
    function void note_request(logic [7:0] b);
      res_t r;
      bit   emit;
      bit   stored;
      r    = '0;
      emit = 1'b0;
      if (sysex_open) begin
        stored = 1'b0;
        if (sysex_len < SYSEX_CAPACITY) begin
          if (sysex_len == 1) maker_id = b;
          else if (sysex_len == 2) device_id = b;
          sysex_len++;
          stored = 1'b1;
        end
        if (b == SYX_END_BYTE) begin
          r.kind         = KIND_SYX_END;
          r.sysex_data   = b;
          r.sysex_length = sysex_len[LEN_W-1:0];
          if (sysex_len > 2 && maker_id == MAKER_ID)
            r.syx_channel = CHAN_W'(device_id[3:0] & DEVICE_CH_MASK) + 1'b1;
          sysex_open = 1'b0;
          sysex_len  = '0;
          emit       = 1'b1;
        end else if (stored) begin
          r.kind         = KIND_SYX_BYTE;
          r.sysex_data   = b;
          r.sysex_length = sysex_len[LEN_W-1:0];
          emit           = 1'b1;
        end
      end else if (b == SYX_START_BYTE) begin
        sysex_open     = 1'b1;
        sysex_len      = 1;
        maker_id       = '0;
        device_id      = '0;
        r.kind         = KIND_SYX_BYTE;
        r.sysex_data   = b;
        r.sysex_length = 1;
        emit           = 1'b1;
      end else if (b >= REALTIME_FIRST) begin
        // drop real-time bytes outside SysEx
      end else if (b >= COMMON_FIRST) begin
        cur_status = '0;
        got_count  = '0;
      end else if (b[7]) begin
        cur_status = b;
        got_count  = '0;
        need_count = (b[7:4] == HI_PROG_CHANGE || b[7:4] == HI_CHAN_PRESS) ? 2'd1 : 2'd2;
      end else if (cur_status != 8'h00) begin
        got_count = got_count + 2'd1;
        if (got_count >= need_count) begin
          got_count     = '0;
          r.kind        = KIND_CHAN;
          r.status_byte = cur_status;
          if (need_count == 2'd2) begin
            r.data_first  = first_data;
            r.data_second = b[6:0];
          end else begin
            r.data_first = b[6:0];
          end
          emit = 1'b1;
        end else begin
          first_data = b[6:0];
        end
      end
      if (emit) pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        fault($sformatf("result with nothing pending: kind %0d sx %02h len %0d",
                        got.kind, got.sysex_data, got.sysex_length));
      end else begin
        exp = pending.pop_front();
        if (got.kind !== exp.kind || got.status_byte !== exp.status_byte ||
            got.data_first !== exp.data_first || got.data_second !== exp.data_second ||
            got.sysex_data !== exp.sysex_data || got.sysex_length !== exp.sysex_length ||
            got.syx_channel !== exp.syx_channel)
          fault($sformatf({"mismatch: expected kind %0d st %02h d1 %02h d2 %02h sx %02h ",
                           "len %0d ch %0d, got kind %0d st %02h d1 %02h d2 %02h sx %02h ",
                           "len %0d ch %0d"},
                          exp.kind, exp.status_byte, exp.data_first, exp.data_second,
                          exp.sysex_data, exp.sysex_length, exp.syx_channel,
                          got.kind, got.status_byte, got.data_first, got.data_second,
                          got.sysex_data, got.sysex_length, got.syx_channel));
      end
    endfunction

    function void close_out();
      if (pending.size() != 0)
        fault($sformatf("%0d results never arrived", pending.size()));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mbsp_rx_if  rx_bus();
  mbsp_res_if res_bus();

  midi_byte_stream_parser DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus.sink),
    .res_o  (res_bus.source)
  );

  parser_scoreboard sb;
  int unsigned      random_items;
  bit               no_gaps;
  bit               rx_hold;
  int unsigned      cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offer one byte, hold it until accepted, then note it.
  task automatic send_request(input logic [7:0] b);
    while (!no_gaps && $urandom_range(0, 99) < 8) begin
      rx_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (rx_bus.ready !== 1'b1);
    sb.note_request(b);
    random_items++;
    @(negedge clk_i);
  endtask

  task automatic send_realtime();
    send_request(8'($urandom_range(REALTIME_FIRST, 8'hFF)));
  endtask

  // Channel messages with running status, sometimes cut short or with real-time inside.
  task automatic send_channel_burst();
    logic [7:0]  status;
    int unsigned msgs;
    int unsigned len;
    status = 8'($urandom_range(8'h80, 8'hEF));
    msgs   = $urandom_range(1, 3);
    len    = (status[7:4] == HI_PROG_CHANGE || status[7:4] == HI_CHAN_PRESS) ? 1 : 2;
    if ($urandom_range(0, 99) < 75) send_request(status);
    for (int m = 0; m < msgs; m++) begin
      for (int d = 0; d < len; d++) begin
        if ($urandom_range(0, 99) < 5) send_realtime();
        if ($urandom_range(0, 99) < 3) return;
        send_request(8'($urandom_range(0, 8'h7F)));
      end
    end
  endtask

  task automatic send_sysex(input int unsigned body_len);
    logic [7:0] b;
    send_request(SYX_START_BYTE);
    for (int unsigned i = 0; i < body_len; i++) begin
      if (i == 0 && $urandom_range(0, 1)) begin
        b = MAKER_ID;
      end else if ($urandom_range(0, 99) < 85) begin
        b = 8'($urandom_range(0, 8'h7F));
      end else begin
        do b = 8'($urandom_range(8'h80, 8'hFF)); while (b == SYX_END_BYTE);
      end
      send_request(b);
    end
    send_request(SYX_END_BYTE);
  endtask

  initial begin
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      res_bus.ready <= !rx_hold && (no_gaps || $urandom_range(0, 99) >= 8);
      @(posedge clk_i);
      if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        sb.check_result('{kind: kind_e'(res_bus.kind), status_byte: res_bus.status_byte,
                          data_first: res_bus.data_first, data_second: res_bus.data_second,
                          sysex_data: res_bus.sysex_data, sysex_length: res_bus.sysex_length,
                          syx_channel: res_bus.syx_channel});
    end
  end

  // Stall the result side for a long stretch so the queue fills and rx ready drops.
  initial begin
    rx_hold = 1'b0;
    @(posedge rst_ni);
    while (random_items < 300) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    logic [7:0] directed[$];
    sb             = new();
    random_items   = 0;
    no_gaps        = 1'b0;
    rst_ni         = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // data without status, extremes of status and data, real-time inside a message,
    // system common clearing status, SysEx with maker id and real-time, minimal SysEx
    directed = '{8'h45, 8'h80, 8'h00, 8'h7F, 8'h55, 8'h2A, 8'hC3, 8'h7F, 8'hD0, 8'h00,
                 8'hEF, 8'h01, 8'hF8, 8'h02, 8'hFF, 8'hF1, 8'h10,
                 8'hF0, 8'h43, 8'h15, 8'hF8, 8'h00, 8'hF7, 8'hF0, 8'hF7};
    foreach (directed[i]) send_request(directed[i]);

    while (random_items < RANDOM_ITEMS) begin
      no_gaps = (random_items >= 1000 && random_items < 1300);
      case ($urandom_range(0, 99)) inside
        [0:49]:  send_channel_burst();
        [50:71]: send_sysex($urandom_range(0, 12));
        [72:79]: send_request(8'($urandom_range(COMMON_FIRST, SYX_END_BYTE)));
        [80:89]: send_realtime();
        default: send_request(8'($urandom));
      endcase
    end
    no_gaps = 1'b0;
    rx_bus.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    sb.close_out();
    if (sb.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
